// ===== hdl/tfd_pkg.sv =====
// ============================================================================
// tfd_pkg
// Shared types, constants and unit tables for the triangle flux density block.
// ============================================================================
package tfd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int COORD_FRAC = 16;
    localparam int LNUM_W     = 24;
    localparam int MUL_LIMB_W = 32;
    localparam int UNIT_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_UNIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXISYMMETRIC = 1'b1;

    localparam logic [UNIT_W-1:0] UNIT_INCH   = 3'd0;
    localparam logic [UNIT_W-1:0] UNIT_MM     = 3'd1;
    localparam logic [UNIT_W-1:0] UNIT_CM     = 3'd2;
    localparam logic [UNIT_W-1:0] UNIT_M      = 3'd3;
    localparam logic [UNIT_W-1:0] UNIT_MIL    = 3'd4;
    localparam logic [UNIT_W-1:0] UNIT_MICRON = 3'd5;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] vx0;
        logic signed [DATA_WIDTH-1:0] vy0;
        logic signed [DATA_WIDTH-1:0] vx1;
        logic signed [DATA_WIDTH-1:0] vy1;
        logic signed [DATA_WIDTH-1:0] vx2;
        logic signed [DATA_WIDTH-1:0] vy2;
        logic signed [DATA_WIDTH-1:0] pot0_re;
        logic signed [DATA_WIDTH-1:0] pot0_im;
        logic signed [DATA_WIDTH-1:0] pot1_re;
        logic signed [DATA_WIDTH-1:0] pot1_im;
        logic signed [DATA_WIDTH-1:0] pot2_re;
        logic signed [DATA_WIDTH-1:0] pot2_im;
    } tfd_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] flux1_re;
        logic signed [DATA_WIDTH-1:0] flux1_im;
        logic signed [DATA_WIDTH-1:0] flux2_re;
        logic signed [DATA_WIDTH-1:0] flux2_im;
        logic                         degenerate;
    } tfd_out_t;

    // The length scale is the exact ratio unit_num / unit_den meters.
    function automatic logic [LNUM_W-1:0] unit_num(input logic [UNIT_W-1:0] u);
        logic [LNUM_W-1:0] r;
        unique case (u)
            UNIT_MM, UNIT_CM, UNIT_M, UNIT_MICRON: r = LNUM_W'(1);
            default:                               r = LNUM_W'(127);
        endcase
        return r;
    endfunction

    function automatic logic [LNUM_W-1:0] unit_den(input logic [UNIT_W-1:0] u);
        logic [LNUM_W-1:0] r;
        unique case (u)
            UNIT_MM:     r = LNUM_W'(1000);
            UNIT_CM:     r = LNUM_W'(100);
            UNIT_M:      r = LNUM_W'(1);
            UNIT_MIL:    r = LNUM_W'(5000000);
            UNIT_MICRON: r = LNUM_W'(1000000);
            default:     r = LNUM_W'(5000);
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/tfd_mul.sv =====
// ============================================================================
// tfd_mul
// Two-stage signed multiplier: limb partial products, then a shifted sum.
// ============================================================================
module tfd_mul #(
    parameter int WA   = 68,
    parameter int WB   = 34,
    parameter int LIMB = tfd_pkg::MUL_LIMB_W
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);
    localparam int NL  = (WA + LIMB - 1) / LIMB;
    localparam int AEW = NL * LIMB;
    localparam int PPW = LIMB + WB + 1;
    localparam int PW  = WA + WB;

    logic signed [AEW-1:0] a_ext;
    logic signed [PPW-1:0] pp_next [NL];
    logic signed [PPW-1:0] pp_reg [NL];
    logic signed [PW-1:0]  p_next;
    logic signed [PW-1:0]  p_reg;

    assign a_ext = AEW'(a);

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            if (i == NL - 1) begin
                pp_next[i] = PPW'($signed(a_ext[i*LIMB +: LIMB]) * b);
            end else begin
                pp_next[i] = PPW'($signed({1'b0, a_ext[i*LIMB +: LIMB]}) * b);
            end
        end
    end

    always_comb begin
        p_next = '0;
        for (int i = 0; i < NL; i++) begin
            p_next = p_next + (PW'(pp_reg[i]) <<< (i * LIMB));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg <= pp_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== hdl/tfd_div_cell.sv =====
// ============================================================================
// tfd_div_cell
// One restoring division step: tries the shifted divisor, yields one bit.
// ============================================================================
module tfd_div_cell #(
    parameter int RW    = 160,
    parameter int DENW  = 128,
    parameter int QW    = 33,
    parameter int SHIFT = 0
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [RW-1:0]   rem_in,
    input  logic [DENW-1:0] den_in,
    input  logic [QW-1:0]   q_in,
    output logic [RW-1:0]   rem_out,
    output logic [DENW-1:0] den_out,
    output logic [QW-1:0]   q_out
);
    logic [RW:0]     diff;
    logic [RW-1:0]   rem_reg;
    logic [DENW-1:0] den_reg;
    logic [QW-1:0]   q_reg;

    assign diff = {1'b0, rem_in} - ((RW + 1)'(den_in) << SHIFT);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= diff[RW] ? rem_in : diff[RW-1:0];
            den_reg <= den_in;
            q_reg   <= {q_in[QW-2:0], ~diff[RW]};
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;

endmodule

// ===== hdl/tfd_div.sv =====
// ============================================================================
// tfd_div
// Chain of division cells, one quotient bit per cell, most significant first.
// ============================================================================
module tfd_div #(
    parameter int RW   = 160,
    parameter int DENW = 128,
    parameter int QW   = 33
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [RW-1:0]   num,
    input  logic [DENW-1:0] den,
    output logic [QW-1:0]   q
);
    logic [RW-1:0]   rem_w [QW+1];
    logic [DENW-1:0] den_w [QW+1];
    logic [QW-1:0]   q_w   [QW+1];

    assign rem_w[0] = num;
    assign den_w[0] = den;
    assign q_w[0]   = '0;

    for (genvar j = 0; j < QW; j++) begin : g_cell
        tfd_div_cell #(
            .RW   (RW),
            .DENW (DENW),
            .QW   (QW),
            .SHIFT(QW - 1 - j)
        ) u_cell (
            .aclk   (aclk),
            .en     (en),
            .rem_in (rem_w[j]),
            .den_in (den_w[j]),
            .q_in   (q_w[j]),
            .rem_out(rem_w[j+1]),
            .den_out(den_w[j+1]),
            .q_out  (q_w[j+1])
        );
    end

    assign q = q_w[QW];

endmodule

// ===== hdl/triangle_element_flux_density.sv =====
// ============================================================================
// triangle_element_flux_density
// Flux density of a first-order triangle from its nodal potentials.
// ============================================================================
// The input channel (s_valid, s_ready, s_data) takes one triangle per
// transfer: three vertices and three complex potentials. The output channel
// (m_valid, m_ready, m_data) returns one result per triangle, in order.
// The user must write the length unit and the axisymmetric mode on the cfg
// port only while the block is idle; the block does not enforce this.
// Throughput is one triangle per cycle while the output is not stalled.
// Most of the latency is the divider chain, 33 cells that each resolve
// one quotient bit; ahead of it lies the front end (differences, products,
// sums and two limb multipliers).
// The whole pipeline advances together. When the output register holds a
// result that the receiver does not take, s_ready drops and every stage
// holds its contents until the transfer completes.
// Reset clears all valid flags and sets inch units in planar mode.
// ============================================================================
module triangle_element_flux_density (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tfd_pkg::tfd_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tfd_pkg::tfd_out_t                 m_data,
    input  logic                              cfg_we,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tfd_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int GW    = DW + 1;
    localparam int SW    = DW + 2;
    localparam int PRW   = DW + GW;
    localparam int TW    = 2 * GW + 2;
    localparam int MAW   = TW + SW;
    localparam int N2W   = MAW + 1;
    localparam int PBW   = N2W + LNUM_W;
    localparam int NUMW  = PBW + COORD_FRAC + 2;
    localparam int DENW  = PBW + 1;
    localparam int RW    = (NUMW > DENW + DW) ? NUMW : DENW + DW;
    localparam int QW    = DW + 1;
    localparam int FRONT = 10;

    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [3:0] neg;
    } tfd_side_t;

    logic [UNIT_W-1:0] unit_reg;
    logic              axi_reg;
    logic              en;
    logic              vld_reg [FRONT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg <= UNIT_INCH;
            axi_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LENGTH_UNIT:  unit_reg <= cfg_wdata[UNIT_W-1:0];
                CFG_AXISYMMETRIC: axi_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Stage 0: input register.
    tfd_in_t in_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_data;
        end
    end

    logic signed [DW-1:0] px [3];
    logic signed [DW-1:0] py [3];
    logic signed [DW-1:0] pot [2][3];
    assign px[0] = in_reg.vx0;
    assign px[1] = in_reg.vx1;
    assign px[2] = in_reg.vx2;
    assign py[0] = in_reg.vy0;
    assign py[1] = in_reg.vy1;
    assign py[2] = in_reg.vy2;
    assign pot[0][0] = in_reg.pot0_re;
    assign pot[1][0] = in_reg.pot0_im;
    assign pot[0][1] = in_reg.pot1_re;
    assign pot[1][1] = in_reg.pot1_im;
    assign pot[0][2] = in_reg.pot2_re;
    assign pot[1][2] = in_reg.pot2_im;

    // Stage 1: gradients and sums.
    logic signed [GW-1:0] gx_reg [3];
    logic signed [GW-1:0] gy_reg [3];
    logic signed [SW-1:0] sumx_reg;
    logic signed [SW-1:0] psum_r1_reg [2];
    logic signed [DW-1:0] pot_r1_reg [2][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            gy_reg[0] <= GW'(py[1]) - GW'(py[2]);
            gy_reg[1] <= GW'(py[2]) - GW'(py[0]);
            gy_reg[2] <= GW'(py[0]) - GW'(py[1]);
            gx_reg[0] <= GW'(px[2]) - GW'(px[1]);
            gx_reg[1] <= GW'(px[0]) - GW'(px[2]);
            gx_reg[2] <= GW'(px[1]) - GW'(px[0]);
            sumx_reg  <= SW'(px[0]) + SW'(px[1]) + SW'(px[2]);
            for (int p = 0; p < 2; p++) begin
                psum_r1_reg[p] <= SW'(pot[p][0]) + SW'(pot[p][1]) + SW'(pot[p][2]);
            end
            pot_r1_reg <= pot;
        end
    end

    // Stage 2: products of gradients and potentials.
    logic signed [2*GW-1:0] ta_reg;
    logic signed [2*GW-1:0] tb_reg;
    logic signed [PRW-1:0]  pgx_reg [2][3];
    logic signed [PRW-1:0]  pgy_reg [2][3];
    logic signed [SW-1:0]   s_r2_reg;
    logic signed [SW-1:0]   psum_r2_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            ta_reg <= gy_reg[0] * gx_reg[1];
            tb_reg <= gy_reg[1] * gx_reg[0];
            for (int p = 0; p < 2; p++) begin
                for (int i = 0; i < 3; i++) begin
                    pgx_reg[p][i] <= pot_r1_reg[p][i] * gx_reg[i];
                    pgy_reg[p][i] <= pot_r1_reg[p][i] * gy_reg[i];
                end
            end
            if (!axi_reg) begin
                s_r2_reg <= SW'(1);
            end else if (sumx_reg == '0) begin
                s_r2_reg <= SW'(3);
            end else begin
                s_r2_reg <= sumx_reg;
            end
            psum_r2_reg <= psum_r1_reg;
        end
    end

    // Stage 3: twice the area and the potential derivatives.
    logic signed [TW-1:0] tarea_reg;
    logic signed [TW-1:0] dy_reg [2];
    logic signed [TW-1:0] dx_reg [2];
    logic signed [SW-1:0] s_r3_reg;
    logic signed [SW-1:0] psum_r3_reg [2];
    logic                 degen_r3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tarea_reg    <= TW'(ta_reg) - TW'(tb_reg);
            degen_r3_reg <= (ta_reg == tb_reg);
            for (int p = 0; p < 2; p++) begin
                dy_reg[p] <= TW'(pgx_reg[p][0]) + TW'(pgx_reg[p][1]) + TW'(pgx_reg[p][2]);
                dx_reg[p] <= TW'(pgy_reg[p][0]) + TW'(pgy_reg[p][1]) + TW'(pgy_reg[p][2]);
            end
            s_r3_reg    <= s_r2_reg;
            psum_r3_reg <= psum_r2_reg;
        end
    end

    // Stages 4 and 5: radius and area products.
    logic signed [MAW-1:0] den0_p;
    logic signed [MAW-1:0] dxs_p [2];
    logic signed [MAW-1:0] pt_p [2];

    tfd_mul #(.WA(TW), .WB(SW)) u_mul_den (
        .aclk(aclk), .en(en), .a(tarea_reg), .b(s_r3_reg), .p(den0_p)
    );

    for (genvar p = 0; p < 2; p++) begin : g_mula
        tfd_mul #(.WA(TW), .WB(SW)) u_mul_dxs (
            .aclk(aclk), .en(en), .a(dx_reg[p]), .b(s_r3_reg), .p(dxs_p[p])
        );
        tfd_mul #(.WA(TW), .WB(SW)) u_mul_pt (
            .aclk(aclk), .en(en), .a(tarea_reg), .b(psum_r3_reg[p]), .p(pt_p[p])
        );
    end

    logic signed [TW-1:0] dy_d1_reg [2];
    logic signed [TW-1:0] dy_d2_reg [2];
    logic                 degen_d_reg [5];

    always_ff @(posedge aclk) begin
        if (en) begin
            dy_d1_reg      <= dy_reg;
            dy_d2_reg      <= dy_d1_reg;
            degen_d_reg[0] <= degen_r3_reg;
            for (int k = 1; k < 5; k++) begin
                degen_d_reg[k] <= degen_d_reg[k-1];
            end
        end
    end

    // Stage 6: numerators before the length scale.
    logic signed [N2W-1:0] den0_reg;
    logic signed [N2W-1:0] n1a_reg [2];
    logic signed [N2W-1:0] n2a_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            den0_reg <= N2W'(den0_p);
            for (int p = 0; p < 2; p++) begin
                if (axi_reg) begin
                    n1a_reg[p] <= (N2W'(dy_d2_reg[p]) <<< (COORD_FRAC + 1))
                                + (N2W'(dy_d2_reg[p]) <<< COORD_FRAC);
                    n2a_reg[p] <= N2W'(dxs_p[p]) + N2W'(pt_p[p]);
                end else begin
                    n1a_reg[p] <= N2W'(dy_d2_reg[p]);
                    n2a_reg[p] <= N2W'(dxs_p[p]);
                end
            end
        end
    end

    // Stages 7 and 8: length unit scaling.
    logic signed [LNUM_W-1:0] lnum;
    logic signed [LNUM_W-1:0] lden;
    logic signed [PBW-1:0]    den_p;
    logic signed [PBW-1:0]    nb_p [4];

    assign lnum = $signed(unit_num(unit_reg));
    assign lden = $signed(unit_den(unit_reg));

    tfd_mul #(.WA(N2W), .WB(LNUM_W)) u_mul_lnum (
        .aclk(aclk), .en(en), .a(den0_reg), .b(lnum), .p(den_p)
    );

    for (genvar p = 0; p < 2; p++) begin : g_mulb
        tfd_mul #(.WA(N2W), .WB(LNUM_W)) u_mul_n1 (
            .aclk(aclk), .en(en), .a(n1a_reg[p]), .b(lden), .p(nb_p[p])
        );
        tfd_mul #(.WA(N2W), .WB(LNUM_W)) u_mul_n2 (
            .aclk(aclk), .en(en), .a(n2a_reg[p]), .b(lden), .p(nb_p[p+2])
        );
    end

    // Stage 9: magnitudes, rounding offset and result signs.
    logic [PBW-1:0]  dmag;
    logic [PBW-1:0]  nmag [4];
    logic [NUMW-1:0] num_reg [4];
    logic [DENW-1:0] den2_reg;
    logic [3:0]      neg_reg;
    logic            degen_r9_reg;

    always_comb begin
        dmag = den_p[PBW-1] ? PBW'(-den_p) : PBW'(den_p);
        for (int l = 0; l < 4; l++) begin
            nmag[l] = nb_p[l][PBW-1] ? PBW'(-nb_p[l]) : PBW'(nb_p[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den2_reg     <= {dmag, 1'b0};
            degen_r9_reg <= degen_d_reg[4];
            for (int l = 0; l < 4; l++) begin
                num_reg[l] <= (NUMW'(nmag[l]) << (COORD_FRAC + 1)) + NUMW'(dmag);
                if (l < 2) begin
                    neg_reg[l] <= nb_p[l][PBW-1] ^ den_p[PBW-1];
                end else begin
                    neg_reg[l] <= ~nb_p[l][PBW-1] ^ den_p[PBW-1];
                end
            end
        end
    end

    // Divider chains.
    logic [QW-1:0] q [4];
    for (genvar l = 0; l < 4; l++) begin : g_div
        tfd_div #(.RW(RW), .DENW(DENW), .QW(QW)) u_div (
            .aclk(aclk),
            .en  (en),
            .num (RW'(num_reg[l])),
            .den (den2_reg),
            .q   (q[l])
        );
    end

    tfd_side_t side_reg [QW];
    tfd_side_t side_in;
    assign side_in = '{valid: vld_reg[FRONT-1], degen: degen_r9_reg, neg: neg_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < FRONT; k++) begin
                vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k < QW; k++) begin
                side_reg[k].valid <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < FRONT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            side_reg[0] <= side_in;
            for (int k = 1; k < QW; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Saturation, sign and output register.
    logic [DW-1:0] res [4];
    logic [QW-1:0] lim [4];
    logic [QW-1:0] qmag [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            lim[l] = QW'(1) << (DW - 1);
            if (!side_reg[QW-1].neg[l]) begin
                lim[l] = lim[l] - QW'(1);
            end
            qmag[l] = (q[l] > lim[l]) ? lim[l] : q[l];
            if (side_reg[QW-1].degen) begin
                res[l] = '0;
            end else if (side_reg[QW-1].neg[l]) begin
                res[l] = DW'(-qmag[l]);
            end else begin
                res[l] = DW'(qmag[l]);
            end
        end
    end

    logic     m_valid_reg;
    tfd_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= side_reg[QW-1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.flux1_re   <= res[0];
            m_data_reg.flux1_im   <= res[1];
            m_data_reg.flux2_re   <= res[2];
            m_data_reg.flux2_im   <= res[3];
            m_data_reg.degenerate <= side_reg[QW-1].degen;
        end
    end

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/tfd_checker.sv =====
// ============================================================================
// tfd_checker
// Port-level checks for the triangle flux density block.
// ============================================================================
module tfd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input tfd_pkg::tfd_in_t               s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input tfd_pkg::tfd_out_t              m_data
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("stalled input transfer changed");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result transfer changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_ready_free: assert property (@(posedge aclk)
        m_ready |-> s_ready)
        else $error("input stalled while the receiver is ready");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.flux1_re == '0 && m_data.flux1_im == '0
            && m_data.flux2_re == '0 && m_data.flux2_im == '0)
        else $error("degenerate triangle with nonzero flux");

endmodule

bind triangle_element_flux_density tfd_checker u_tfd_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Testbench for triangle_element_flux_density. Triangles stream in with
// bursty valid and a stalling receiver. Every result is checked field by
// field against a predictor built on exact wide integers, across planar and
// axisymmetric modes and all length units.
// ============================================================================
module tb;
    import tfd_pkg::*;

    typedef logic signed [255:0] wint_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    tfd_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    tfd_out_t              m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LENGTH_UNIT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    tfd_in_t  pending_tris[$];
    tfd_out_t expected_flux[$];
    logic [UNIT_W-1:0] cur_unit = UNIT_INCH;
    logic              cur_axi = 1'b0;
    int errors = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    triangle_element_flux_density dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #4 aclk = ~aclk;

    function automatic wint_t unit_numer(logic [UNIT_W-1:0] u);
        wint_t r;
        case (u)
            UNIT_MM, UNIT_CM, UNIT_M, UNIT_MICRON: r = 1;
            default: r = 127;
        endcase
        return r;
    endfunction

    function automatic wint_t unit_denom(logic [UNIT_W-1:0] u);
        wint_t r;
        case (u)
            UNIT_MM:     r = 1000;
            UNIT_CM:     r = 100;
            UNIT_M:      r = 1;
            UNIT_MIL:    r = 5000000;
            UNIT_MICRON: r = 1000000;
            default:     r = 5000;
        endcase
        return r;
    endfunction

    // Ratio rounded to nearest with ties away from zero, then saturated.
    function automatic logic [31:0] rounded_ratio(wint_t n, wint_t d);
        logic  ng;
        wint_t an, ad, q, lim;
        ng = (n < 0) != (d < 0);
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        lim = ng ? 256'sh8000_0000 : 256'sh7fff_ffff;
        if (q > lim) q = lim;
        return ng ? -q[31:0] : q[31:0];
    endfunction

    function automatic tfd_out_t element_flux(tfd_in_t t);
        wint_t px[3], py[3], gy[3], gx[3], pt[3];
        wint_t area, sx, ln, ld, dy, dx, ps, n1, n2, dn;
        tfd_out_t r;
        px[0] = $signed(t.vx0); py[0] = $signed(t.vy0);
        px[1] = $signed(t.vx1); py[1] = $signed(t.vy1);
        px[2] = $signed(t.vx2); py[2] = $signed(t.vy2);
        for (int i = 0; i < 3; i++) begin
            gy[i] = py[(i + 1) % 3] - py[(i + 2) % 3];
            gx[i] = px[(i + 2) % 3] - px[(i + 1) % 3];
        end
        area = gy[0] * gx[1] - gy[1] * gx[0];
        r = '0;
        if (area == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        ln = unit_numer(cur_unit);
        ld = unit_denom(cur_unit);
        sx = px[0] + px[1] + px[2];
        if (sx == 0) sx = 3;
        for (int part = 0; part < 2; part++) begin
            pt[0] = part ? $signed(t.pot0_im) : $signed(t.pot0_re);
            pt[1] = part ? $signed(t.pot1_im) : $signed(t.pot1_re);
            pt[2] = part ? $signed(t.pot2_im) : $signed(t.pot2_re);
            dy = 0; dx = 0; ps = 0;
            for (int i = 0; i < 3; i++) begin
                dy = dy + pt[i] * gx[i];
                dx = dx + pt[i] * gy[i];
                ps = ps + pt[i];
            end
            if (!cur_axi) begin
                n1 = dy * 65536 * ld;
                n2 = -(dx * 65536 * ld);
                dn = area * ln;
            end else begin
                n1 = dy * 3 * 65536 * 65536 * ld;
                n2 = -((dx * sx + ps * area) * 65536 * ld);
                dn = area * sx * ln;
            end
            if (part == 0) begin
                r.flux1_re = rounded_ratio(n1, dn);
                r.flux2_re = rounded_ratio(n2, dn);
            end else begin
                r.flux1_im = rounded_ratio(n1, dn);
                r.flux2_im = rounded_ratio(n2, dn);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_extreme();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'h0;
            3: v = 32'hffff_ffff;
            4: v = 32'h1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_pot();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 2**26) - 2**25;
            3: v = $urandom_range(0, 2000) - 1000;
            default: v = pick_extreme();
        endcase
        return v;
    endfunction

    function automatic tfd_in_t random_tri();
        tfd_in_t t;
        logic [31:0] bx, by;
        int k;
        t.pot0_re = pick_pot(); t.pot0_im = pick_pot();
        t.pot1_re = pick_pot(); t.pot1_im = pick_pot();
        t.pot2_re = pick_pot(); t.pot2_im = pick_pot();
        bx = $urandom_range(0, 2**22) - 2**21;
        by = $urandom_range(0, 2**22) - 2**21;
        case ($urandom_range(0, 9))
            5: begin
                t.vx0 = $urandom; t.vy0 = $urandom; t.vx1 = $urandom;
                t.vy1 = $urandom; t.vx2 = $urandom; t.vy2 = $urandom;
            end
            6: begin
                k = $urandom_range(0, 6) - 3;
                t.vx0 = bx; t.vy0 = by;
                t.vx1 = bx + $urandom_range(0, 2**18) - 2**17;
                t.vy1 = by + $urandom_range(0, 2**18) - 2**17;
                t.vx2 = t.vx0 + k * (t.vx1 - t.vx0);
                t.vy2 = t.vy0 + k * (t.vy1 - t.vy0);
            end
            7: begin
                t.vx0 = bx; t.vy0 = by;
                t.vx1 = $urandom_range(0, 2**20) - 2**19;
                t.vy1 = $urandom_range(0, 2**20) - 2**19;
                t.vx2 = -(t.vx0 + t.vx1);
                t.vy2 = $urandom_range(0, 2**20) - 2**19;
            end
            8: begin
                t.vx0 = pick_extreme(); t.vy0 = pick_extreme();
                t.vx1 = pick_extreme(); t.vy1 = pick_extreme();
                t.vx2 = pick_extreme(); t.vy2 = pick_extreme();
            end
            9: begin
                t.vx0 = $urandom_range(0, 32) - 16; t.vy0 = $urandom_range(0, 32) - 16;
                t.vx1 = $urandom_range(0, 32) - 16; t.vy1 = $urandom_range(0, 32) - 16;
                t.vx2 = $urandom_range(0, 32) - 16; t.vy2 = $urandom_range(0, 32) - 16;
            end
            default: begin
                t.vx0 = bx; t.vy0 = by;
                t.vx1 = bx + $urandom_range(0, 2**19) - 2**18;
                t.vy1 = by + $urandom_range(0, 2**19) - 2**18;
                t.vx2 = bx + $urandom_range(0, 2**19) - 2**18;
                t.vy2 = by + $urandom_range(0, 2**19) - 2**18;
            end
        endcase
        return t;
    endfunction

    function automatic tfd_in_t make_tri(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                                         logic [31:0] y1, logic [31:0] x2, logic [31:0] y2,
                                         logic [31:0] pa, logic [31:0] pb, logic [31:0] pc);
        tfd_in_t t;
        t.vx0 = x0; t.vy0 = y0; t.vx1 = x1; t.vy1 = y1; t.vx2 = x2; t.vy2 = y2;
        t.pot0_re = pa; t.pot0_im = pc; t.pot1_re = pb;
        t.pot1_im = pa; t.pot2_re = pc; t.pot2_im = pb;
        return t;
    endfunction

    function automatic void add_tri(tfd_in_t t);
        pending_tris.insert(pending_tris.size(), t);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_flux.insert(expected_flux.size(), element_flux(s_data));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_tris.size() > 0) begin
                    s_data <= pending_tris.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(5, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        tfd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_flux.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("unexpected result %h", m_data);
            end else begin
                want = expected_flux.pop_front();
                if (want !== m_data) begin
                    errors <= errors + 1;
                    if (errors < 10) begin
                        $display("mismatch: expected %h %h %h %h %b", want.flux1_re,
                                 want.flux1_im, want.flux2_re, want.flux2_im, want.degenerate);
                        $display("          actual   %h %h %h %h %b", m_data.flux1_re,
                                 m_data.flux1_im, m_data.flux2_re, m_data.flux2_im,
                                 m_data.degenerate);
                    end
                end
            end
        end
    end

    task automatic drain();
        while (pending_tris.size() > 0 || s_valid || expected_flux.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_config(logic [UNIT_W-1:0] u, logic a);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_LENGTH_UNIT;
        cfg_wdata <= u;
        @(posedge aclk);
        cfg_index <= CFG_AXISYMMETRIC;
        cfg_wdata <= CFG_DATA_W'(a);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_unit = u;
        cur_axi = a;
    endtask

    initial begin
        logic [UNIT_W-1:0] units[8];
        logic              axis[8];
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MX = 32'h7fff_ffff;
        localparam logic [31:0] MN = 32'h8000_0000;
        units = '{UNIT_M, UNIT_MIL, UNIT_MICRON, UNIT_MM, UNIT_CM, 3'd7, 3'd6, UNIT_INCH};
        axis = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        add_tri('0);
        add_tri(make_tri(0, 0, ONE, 0, 0, ONE, MX, MN, 0));
        add_tri(make_tri(0, 0, ONE, 0, 0, ONE, MN, MN, MX));
        add_tri(make_tri(0, 0, 1, 0, 0, 1, MX, MN, MX));
        add_tri(make_tri(MN, MN, MX, MN, MN, MX, MX, MX, MN));
        add_tri(make_tri(MX, MX, MN, MX, MX, MN, MN, 1, -1));
        add_tri(make_tri(MN, 0, MX, 0, 0, MX, 1, 0, -1));
        add_tri(make_tri(ONE, ONE, ONE, ONE, 0, ONE, MX, 5, 7));
        add_tri(make_tri(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 3, MN, MX));
        add_tri(make_tri(-ONE, 0, 0, 5 * ONE, ONE, 0, ONE, 2 * ONE, 0));
        add_tri(make_tri(-3 * ONE, 0, -ONE, ONE, -2 * ONE, -ONE, MX, 0, MN));
        add_tri(make_tri(MX, 0, MX, 1, MX - 1, 0, MX, MN, 0));
        for (int i = 0; i < 180; i++) add_tri(random_tri());
        drain();
        for (int p = 0; p < 8; p++) begin
            write_config(units[p], axis[p]);
            if (units[p] == UNIT_MIL) begin
                add_tri(make_tri(-ONE, 0, 0, 5 * ONE, ONE, 0, MX, MN, 0));
                add_tri(make_tri(MN, MN, MX, MN, MN, MX, MN, MN, MX));
                add_tri(make_tri(-3 * ONE, 0, -ONE, ONE, -2 * ONE, -ONE, MX, 0, MN));
            end
            for (int i = 0; i < 185; i++) add_tri(random_tri());
            drain();
        end
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #(8 * 600000);
        $display("tb: errors");
        $finish;
    end

endmodule
